// ===== rtl/core/bis_pkg.sv =====
`default_nettype none

package bis_pkg;

    localparam int VALUE_W = 32;
    localparam int PROBE_W = 10;
    localparam int SHIFT_W = 12;

    // counts stick at all ones
    localparam logic [PROBE_W-1:0] PROBE_MAX = '1;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = '1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      is_final;
        logic [PROBE_W-1:0]        compare_count;
        logic [SHIFT_W-1:0]        move_count;
        logic                      overflowed;
    } result_t;

    typedef struct packed {
        logic accept;
        logic probe_issue;
        logic probe_resolve;
        logic shift_init;
        logic shift_run;
        logic place;
        logic emit_issue;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic in_last;
        logic item_last;
        logic search_more;
        logic no_shift;
        logic shift_done;
        logic emit_final;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bis_stream_if.sv =====
`default_nettype none

interface bis_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bis_ctrl.sv =====
`default_nettype none

module bis_ctrl
    import bis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_RESOLVE,
        S_SHIFT,
        S_PLACE,
        S_EMIT_RD,
        S_EMIT_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && ready_reg)
                begin
                    cmd.accept = 1'b1;
                    if (status.full)
                        state_next = status.in_last ? S_EMIT_RD : S_IDLE;
                    else if (status.empty)
                        state_next = S_PLACE;
                    else
                        state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                cmd.probe_issue = 1'b1;
                state_next      = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                cmd.probe_resolve = 1'b1;
                if (status.search_more)
                    state_next = S_PROBE;
                else if (status.no_shift)
                    state_next = S_PLACE;
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_run = 1'b1;
                if (status.shift_done)
                    state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = status.item_last ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD:
            begin
                cmd.emit_issue = 1'b1;
                state_next     = S_EMIT_LOAD;
            end
            S_EMIT_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = status.emit_final ? S_IDLE : S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign item_ready = ready_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bis_dpath.sv =====
`default_nettype none

module bis_dpath
    import bis_pkg::*;
#(
    parameter int MAX_ELEMS = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item_data,
    input  logic    result_ready,
    output logic    result_valid,
    output result_t result_data,
    input  cmd_t    cmd,
    output status_t status
);

    localparam int ADDR_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int FILL_W = $clog2(MAX_ELEMS + 1);

    logic [VALUE_W-1:0] store_mem [MAX_ELEMS];

    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      last_reg, last_next;
    logic [FILL_W-1:0]         fill_reg, fill_next;
    logic [FILL_W-1:0]         lo_reg, lo_next;
    logic [FILL_W-1:0]         hi_reg, hi_next;
    logic [ADDR_W-1:0]         mid_reg, mid_next;
    logic [PROBE_W-1:0]        probe_reg, probe_next;
    logic [SHIFT_W-1:0]        shift_reg, shift_next;
    logic                      ovf_reg, ovf_next;
    logic [ADDR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic                      rd_active_reg, rd_active_next;
    logic                      wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]         wr_addr_reg, wr_addr_next;
    logic [ADDR_W-1:0]         emit_ptr_reg, emit_ptr_next;
    logic                      out_valid_reg, out_valid_next;
    result_t                   out_reg;
    logic [VALUE_W-1:0]        rdata_reg;

    logic [FILL_W:0]    mid_sum;
    logic [ADDR_W-1:0]  mid;
    logic               probe_greater;
    logic [FILL_W-1:0]  lo_res;
    logic [FILL_W-1:0]  hi_res;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               emit_final;

    // midpoint of the half-open window [lo, hi)
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - {{FILL_W{1'b0}}, 1'b1};
    assign mid     = mid_sum[ADDR_W:1];

    // equal keys go right, so the sort stays stable
    assign probe_greater = $signed(rdata_reg) > value_reg;
    assign lo_res        = probe_greater ? lo_reg : FILL_W'(mid_reg) + FILL_W'(1);
    assign hi_res        = probe_greater ? FILL_W'(mid_reg) : hi_reg;

    assign emit_final = (FILL_W'(emit_ptr_reg) + FILL_W'(1)) == fill_reg;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = emit_ptr_reg;
        if (cmd.probe_issue)
        begin
            rd_en   = 1'b1;
            rd_addr = mid;
        end
        else if (cmd.shift_run && rd_active_reg)
        begin
            rd_en   = 1'b1;
            rd_addr = rd_ptr_reg;
        end
        else if (cmd.emit_issue)
        begin
            rd_en = 1'b1;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = rdata_reg;
        if (cmd.shift_run && wr_pend_reg)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.place)
        begin
            mem_we    = 1'b1;
            mem_waddr = lo_reg[ADDR_W-1:0];
            mem_wdata = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rdata_reg <= store_mem[rd_addr];
    end

    always_comb
    begin
        value_next     = value_reg;
        last_next      = last_reg;
        fill_next      = fill_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        probe_next     = probe_reg;
        shift_next     = shift_reg;
        ovf_next       = ovf_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_active_next = rd_active_reg;
        wr_addr_next   = wr_addr_reg;
        emit_ptr_next  = emit_ptr_reg;
        out_valid_next = out_valid_reg;
        wr_pend_next   = cmd.shift_run && rd_active_reg;

        if (cmd.accept)
        begin
            value_next = item_data.value;
            last_next  = item_data.is_last;
            lo_next    = '0;
            hi_next    = fill_reg;
            if (status.full)
                ovf_next = 1'b1;
        end

        if (cmd.probe_issue)
        begin
            mid_next = mid;
            if (probe_reg != PROBE_MAX)
                probe_next = probe_reg + PROBE_W'(1);
        end

        if (cmd.probe_resolve)
        begin
            lo_next = lo_res;
            hi_next = hi_res;
        end

        if (cmd.shift_init)
        begin
            rd_ptr_next    = ADDR_W'(fill_reg - FILL_W'(1));
            rd_active_next = 1'b1;
        end

        // read at ptr while the previously read word lands one place up
        if (cmd.shift_run)
        begin
            if (rd_active_reg)
            begin
                wr_addr_next   = rd_ptr_reg + ADDR_W'(1);
                rd_active_next = FILL_W'(rd_ptr_reg) != lo_reg;
                rd_ptr_next    = rd_ptr_reg - ADDR_W'(1);
            end
            if (wr_pend_reg && shift_reg != SHIFT_MAX)
                shift_next = shift_reg + SHIFT_W'(1);
        end

        if (cmd.place)
            fill_next = fill_reg + FILL_W'(1);

        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
            if (emit_final)
            begin
                emit_ptr_next = '0;
                fill_next     = '0;
                probe_next    = '0;
                shift_next    = '0;
                ovf_next      = 1'b0;
            end
            else
            begin
                emit_ptr_next = emit_ptr_reg + ADDR_W'(1);
            end
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            probe_reg     <= '0;
            shift_reg     <= '0;
            ovf_reg       <= 1'b0;
            rd_active_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            emit_ptr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            probe_reg     <= probe_next;
            shift_reg     <= shift_next;
            ovf_reg       <= ovf_next;
            rd_active_reg <= rd_active_next;
            wr_pend_reg   <= wr_pend_next;
            emit_ptr_reg  <= emit_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        last_reg    <= last_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        rd_ptr_reg  <= rd_ptr_next;
        wr_addr_reg <= wr_addr_next;
        if (cmd.emit_load)
        begin
            out_reg.sorted_value  <= $signed(rdata_reg);
            out_reg.is_final      <= emit_final;
            out_reg.compare_count <= probe_reg;
            out_reg.move_count    <= shift_reg;
            out_reg.overflowed    <= ovf_reg;
        end
    end

    assign status.full        = fill_reg == FILL_W'(MAX_ELEMS);
    assign status.empty       = fill_reg == '0;
    assign status.in_last     = item_data.is_last;
    assign status.item_last   = last_reg;
    assign status.search_more = lo_res < hi_res;
    assign status.no_shift    = lo_res == fill_reg;
    assign status.shift_done  = wr_pend_reg && !rd_active_reg;
    assign status.emit_final  = emit_final;
    assign status.out_free    = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/binary_insertion_sorter.sv =====
// channel   dir   payload                                                         beat
// item      in    value[31:0] signed, is_last                                     valid && ready
// result    out   sorted_value[31:0] signed, is_final, compare_count[9:0],
//                 move_count[11:0], overflowed                                    valid && ready
//
// an insert runs the accept, each probe and resolve, the shift (only if entries move) and
// the final write in turn; the store has one read and one write port
// an item meeting a full store is dropped; the drain reads, then loads, each result beat
// reset clears counts, fill, flags and the emit pointer; the store stays unknown until written
// item ready is low while an insert or drain runs; a stalled result holds the drain
// and a new item is taken while the final result beat still waits
`default_nettype none

module binary_insertion_sorter
    import bis_pkg::*;
#(
    parameter int MAX_ELEMS = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    bis_stream_if.sink   item,
    bis_stream_if.source result
);

    cmd_t    cmd;
    status_t status;
    item_t   item_data;
    result_t result_data;

    assign item_data      = item.payload;
    assign result.payload = result_data;

    bis_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    bis_dpath #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_data    (item_data),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .result_data  (result_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bis_checker.sv =====
`default_nettype none

module bis_checker
    import bis_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_ready,
    input wire item_t   item_data,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result_data
);

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result beat changed while stalled");

    // no item taken mid-drain
    a_no_accept_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.is_final |-> !item_ready)
        else $error("item ready during drain of a set");

    // a last item always starts work that blocks the input
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_data.is_last |=> !item_ready)
        else $error("input ready right after a last item");

endmodule

bind binary_insertion_sorter bis_checker u_bis_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_data    (item.payload),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.payload)
);

`default_nettype wire
